@@ hdl/hnm_pkg.sv @@
// Package for the height map to normal map block.
// Holds shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

    // Input kinds carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BUMP_STRENGTH = 2'd2;

    // z component of the unnormalized vector and its square
    localparam logic signed [24:0] UNIT_K    = 25'sd65280;
    localparam logic [47:0]        UNIT_K_SQ = 48'd4261478400;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_L,
        ST_RD_R,
        ST_RD_D,
        ST_RD_U,
        ST_MUL_A,
        ST_MUL_B,
        ST_SQ_A,
        ST_SQ_B,
        ST_SUM,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        NB_LEFT,
        NB_RIGHT,
        NB_DOWN,
        NB_UP
    } nbr_t;

    typedef enum logic [1:0] {
        MS_DX,
        MS_DY,
        MS_SQ_A,
        MS_SQ_B
    } mul_sel_t;

    typedef enum logic [1:0] {
        CMP_X,
        CMP_Y,
        CMP_Z
    } comp_t;

    typedef struct packed {
        logic     accept;
        logic     rd_en;
        nbr_t     rd_sel;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum;
        logic     sqrt_step;
        logic     div_load;
        logic     div_step;
        logic     div_last;
        comp_t    comp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_inside;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ hdl/hnm_ctrl.sv @@
// Controller state machine for the height map to normal map block.
// Depends on hnm_pkg; drives the datapath through hnm_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module hnm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire hnm_pkg::status_t status,
    output hnm_pkg::cmd_t         cmd
);

    hnm_pkg::state_t state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    hnm_pkg::comp_t  comp_reg, comp_next;

    // State and step counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hnm_pkg::ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= hnm_pkg::CMP_X;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.comp   = comp_reg;
        case (state_reg)
            hnm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.in_query) begin
                        state_next = status.in_inside ? hnm_pkg::ST_RD_L : hnm_pkg::ST_LOAD;
                    end
                end
            end
            hnm_pkg::ST_RD_L: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = hnm_pkg::NB_LEFT;
                state_next = hnm_pkg::ST_RD_R;
            end
            hnm_pkg::ST_RD_R: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = hnm_pkg::NB_RIGHT;
                state_next = hnm_pkg::ST_RD_D;
            end
            hnm_pkg::ST_RD_D: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = hnm_pkg::NB_DOWN;
                state_next = hnm_pkg::ST_RD_U;
            end
            hnm_pkg::ST_RD_U: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = hnm_pkg::NB_UP;
                state_next = hnm_pkg::ST_MUL_A;
            end
            hnm_pkg::ST_MUL_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hnm_pkg::MS_DX;
                state_next  = hnm_pkg::ST_MUL_B;
            end
            hnm_pkg::ST_MUL_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hnm_pkg::MS_DY;
                state_next  = hnm_pkg::ST_SQ_A;
            end
            hnm_pkg::ST_SQ_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hnm_pkg::MS_SQ_A;
                state_next  = hnm_pkg::ST_SQ_B;
            end
            hnm_pkg::ST_SQ_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hnm_pkg::MS_SQ_B;
                state_next  = hnm_pkg::ST_SUM;
            end
            hnm_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = hnm_pkg::ST_SQRT;
            end
            hnm_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == 5'(hnm_pkg::SQRT_STEPS - 1)) begin
                    comp_next  = hnm_pkg::CMP_X;
                    state_next = hnm_pkg::ST_DIV_LOAD;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            hnm_pkg::ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = hnm_pkg::ST_DIV_STEP;
            end
            hnm_pkg::ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 5'(hnm_pkg::DIV_STEPS - 1)) begin
                    cmd.div_last = 1'b1;
                    case (comp_reg)
                        hnm_pkg::CMP_X: begin
                            comp_next  = hnm_pkg::CMP_Y;
                            state_next = hnm_pkg::ST_DIV_LOAD;
                        end
                        hnm_pkg::CMP_Y: begin
                            comp_next  = hnm_pkg::CMP_Z;
                            state_next = hnm_pkg::ST_DIV_LOAD;
                        end
                        default: begin
                            state_next = hnm_pkg::ST_LOAD;
                        end
                    endcase
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            hnm_pkg::ST_LOAD: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = hnm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hnm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/hnm_datapath.sv @@
// Datapath: configuration registers, height store, multiplier, square root
// and divider units, output register. Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hnm_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_wr_index,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic [23:0]   s_tdata,
    input  wire logic [0:0]    s_tuser,
    input  wire logic          m_tready,
    output logic               m_tvalid,
    output logic [23:0]        m_tdata,
    output logic [0:0]         m_tuser,
    input  wire hnm_pkg::cmd_t cmd,
    output hnm_pkg::status_t   status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [8:0]        cfg_w_reg, cfg_h_reg;
    logic signed [15:0] strength_reg;
    logic [8:0]        w_eff, h_eff;

    logic [7:0] in_col, in_row, in_hv;
    logic       in_inside, mem_we;
    logic [AW-1:0] wr_addr, rd_addr;

    logic [7:0] col_reg, row_reg;
    logic       bad_reg;
    logic [8:0] c9, r9, cl, cr, rdn, rup, rcol, rrow;

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] mem_q_reg;
    logic       rd_pend_reg;
    hnm_pkg::nbr_t rd_sel_pend_reg;
    logic [7:0] l_reg, r_reg, d_reg, u_reg;

    logic signed [8:0]  dx, dy;
    logic signed [24:0] op_a, op_b, a_reg, b_reg;
    logic signed [49:0] prod;
    logic [46:0]        sa_reg, sb_reg;

    logic [63:0] x_reg, root_reg, bit_reg, trial;
    logic [31:0] len_m;

    logic signed [24:0] comp_val;
    logic signed [34:0] num;
    logic signed [42:0] nscaled;
    logic [41:0]        nclip;
    logic [42:0]        rem_reg, dv_reg;
    logic [8:0]         quot_reg, quot_next;
    logic               ge;
    logic [7:0]         byte_val;
    logic [7:0]         nx_reg, ny_reg, nz_reg;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        m_bad_reg;

    function automatic logic [AW-1:0] addr_of(input logic [8:0] c, input logic [8:0] r);
        addr_of = AW'(AW'(r) * AW'(MAX_WIDTH) + AW'(c));
    endfunction

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg    <= 9'd256;
            cfg_h_reg    <= 9'd256;
            strength_reg <= 16'sd256;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                hnm_pkg::REG_IMAGE_WIDTH:   cfg_w_reg    <= cfg_wr_data[8:0];
                hnm_pkg::REG_IMAGE_HEIGHT:  cfg_h_reg    <= cfg_wr_data[8:0];
                hnm_pkg::REG_BUMP_STRENGTH: strength_reg <= $signed(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // Active size limited to the store dimensions
    assign w_eff = (13'(cfg_w_reg) > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg_w_reg;
    assign h_eff = (13'(cfg_h_reg) > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg_h_reg;

    // Unpack the input transaction
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_hv     = s_tdata[23:16];
    assign in_inside = ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);

    assign status.in_query  = (s_tuser[0] == hnm_pkg::OP_QUERY);
    assign status.in_inside = in_inside;
    assign status.out_free  = !m_valid_reg || m_tready;

    assign mem_we  = cmd.accept && (s_tuser[0] == hnm_pkg::OP_WRITE) && in_inside;
    assign wr_addr = addr_of({1'b0, in_col}, {1'b0, in_row});

    // Latch the query coordinate
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            col_reg <= in_col;
            row_reg <= in_row;
            bad_reg <= !in_inside;
        end
    end

    // Wrapped neighbor coordinates
    assign c9   = {1'b0, col_reg};
    assign r9   = {1'b0, row_reg};
    assign cl   = (c9 == 9'd0) ? w_eff - 9'd1 : c9 - 9'd1;
    assign cr   = (c9 + 9'd1 == w_eff) ? 9'd0 : c9 + 9'd1;
    assign rdn  = (r9 == 9'd0) ? h_eff - 9'd1 : r9 - 9'd1;
    assign rup  = (r9 + 9'd1 == h_eff) ? 9'd0 : r9 + 9'd1;

    always_comb begin
        case (cmd.rd_sel)
            hnm_pkg::NB_LEFT:  begin rcol = cl; rrow = r9;  end
            hnm_pkg::NB_RIGHT: begin rcol = cr; rrow = r9;  end
            hnm_pkg::NB_DOWN:  begin rcol = c9; rrow = rdn; end
            default:           begin rcol = c9; rrow = rup; end
        endcase
    end
    assign rd_addr = addr_of(rcol, rrow);

    // Height store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_hv;
        end
        if (cmd.rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
        end
    end

    // Capture each neighbor in the cycle after its read
    always_ff @(posedge aclk) begin
        rd_sel_pend_reg <= cmd.rd_sel;
        if (rd_pend_reg) begin
            case (rd_sel_pend_reg)
                hnm_pkg::NB_LEFT:  l_reg <= mem_q_reg;
                hnm_pkg::NB_RIGHT: r_reg <= mem_q_reg;
                hnm_pkg::NB_DOWN:  d_reg <= mem_q_reg;
                default:           u_reg <= mem_q_reg;
            endcase
        end
    end

    // Shared multiplier: slopes, then their squares
    assign dx = $signed({1'b0, l_reg}) - $signed({1'b0, r_reg});
    assign dy = $signed({1'b0, d_reg}) - $signed({1'b0, u_reg});

    always_comb begin
        case (cmd.mul_sel)
            hnm_pkg::MS_DX:   begin op_a = 25'(dx);  op_b = 25'(strength_reg); end
            hnm_pkg::MS_DY:   begin op_a = 25'(dy);  op_b = 25'(strength_reg); end
            hnm_pkg::MS_SQ_A: begin op_a = a_reg;    op_b = a_reg;             end
            default:          begin op_a = b_reg;    op_b = b_reg;             end
        endcase
    end
    assign prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                hnm_pkg::MS_DX:   a_reg  <= 25'(prod);
                hnm_pkg::MS_DY:   b_reg  <= 25'(prod);
                hnm_pkg::MS_SQ_A: sa_reg <= 47'(prod);
                default:          sb_reg <= 47'(prod);
            endcase
        end
    end

    // Square root, two radicand bits per step
    assign trial = root_reg + bit_reg;
    assign len_m = root_reg[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            x_reg    <= {48'(sa_reg) + 48'(sb_reg) + hnm_pkg::UNIT_K_SQ, 16'd0};
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end else if (cmd.sqrt_step) begin
            if (x_reg >= trial) begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Divider numerator for the selected component
    always_comb begin
        case (cmd.comp)
            hnm_pkg::CMP_X: comp_val = a_reg;
            hnm_pkg::CMP_Y: comp_val = b_reg;
            hnm_pkg::CMP_Z: comp_val = hnm_pkg::UNIT_K;
            default:        comp_val = '0;
        endcase
    end
    assign num     = (35'(comp_val) <<< 8) + $signed({3'd0, len_m});
    assign nscaled = (43'(num) <<< 8) - 43'(num);
    assign nclip   = nscaled[42] ? 42'd0 : nscaled[41:0];

    // Restoring division, one quotient bit per step
    assign ge        = (rem_reg >= dv_reg);
    assign quot_next = {quot_reg[7:0], ge};
    assign byte_val  = quot_next[8] ? 8'hFF : quot_next[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg  <= 43'(nclip) + 43'(len_m);
            dv_reg   <= {2'd0, len_m, 9'd0};
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - dv_reg;
            end
            dv_reg   <= dv_reg >> 1;
            quot_reg <= quot_next;
            if (cmd.div_last) begin
                case (cmd.comp)
                    hnm_pkg::CMP_X: nx_reg <= byte_val;
                    hnm_pkg::CMP_Y: ny_reg <= byte_val;
                    default:        nz_reg <= byte_val;
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= bad_reg ? 24'd0 : {nz_reg, ny_reg, nx_reg};
            m_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_bad_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");
    a_port_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !cmd.rd_en)
        else $error("store written and read in one cycle");
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> (root_reg[63:32] == 32'd0))
        else $error("vector length exceeds 32 bits");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && bad_reg) |=> (m_tdata == 24'd0 && m_tuser[0] == 1'b1))
        else $error("flagged result carries nonzero data");
`endif

endmodule
`default_nettype wire

@@ hdl/height_to_normal_map_top.sv @@
// Query path: an inside query does 4 store reads, 4 multiplies, a sum, 32 square
// root steps and three divider passes, one per component; an outside query none.
// Flow: every query holds off the next item until its result is loaded into a free
// output register; writes are taken one per cycle between queries.
// Reset: aresetn synchronous active low; clears control and config registers,
// the height store is not cleared.
// Top level: joins hnm_ctrl and hnm_datapath. Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module height_to_normal_map_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // col, row, height_value
    input  wire logic [0:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // normal_x, normal_y, normal_z
    output logic [0:0]       m_tuser    // bad_coord
);

    hnm_pkg::cmd_t    cmd;
    hnm_pkg::status_t status;

    hnm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hnm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
`default_nettype wire

@@ tb/height_to_normal_map_top_tb.sv @@
// Self-checking testbench for height_to_normal_map_top: stores height samples,
// queries normals and compares them with an in-bench fixed-point predictor.
// Depends on hnm_pkg and the height_to_normal_map_top RTL.
`timescale 1ns / 1ps
module height_to_normal_map_top_tb;

    localparam int MAXW = 256;
    localparam int MAXH = 256;
    localparam int K_UNIT = 65280;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic       bad;
    } normal_t;

    typedef struct {
        logic       op;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] hv;
        logic       known;
        normal_t    res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    height_to_normal_map_top u_dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: shadow of the height store and the registers
    logic [7:0]         heights [MAXW*MAXH];
    bit                 written [MAXW*MAXH];
    int unsigned        act_w, act_h;
    int                 strength;
    normal_t            pending_normals[$];
    int                 mismatches = 0;
    int                 queries_seen = 0;
    int                 bad_seen = 0;
    int                 idle_cycles = 0;
    bit                 hold_off = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [7:0] to_byte(longint comp, longint len);
        longint num, q;
        num = 255 * (comp * 256 + len);
        if (num < 0) num = 0;
        q = (2 * num + 2 * len) / (4 * len);
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic longint ht(int unsigned c, int unsigned r);
        return longint'(heights[r*MAXW + c]);
    endfunction

    // Apply one item to the shadow store; return 1 with a normal for queries
    function automatic bit predict_normal(logic op, int unsigned c, int unsigned r,
                                          logic [7:0] hv, output normal_t n);
        bit in_range;
        int unsigned cl, cr, rd, ru;
        longint a, b, len;
        longint unsigned q;
        in_range = c < act_w && r < act_h;
        n = '0;
        if (op == hnm_pkg::OP_WRITE) begin
            if (in_range) begin
                heights[r*MAXW + c] = hv;
                written[r*MAXW + c] = 1'b1;
            end
            return 1'b0;
        end
        if (!in_range) begin
            n.bad = 1'b1;
            return 1'b1;
        end
        cl = c == 0 ? act_w - 1 : c - 1;
        cr = c + 1 == act_w ? 0 : c + 1;
        rd = r == 0 ? act_h - 1 : r - 1;
        ru = r + 1 == act_h ? 0 : r + 1;
        a = (ht(cl, r) - ht(cr, r)) * strength;
        b = (ht(c, rd) - ht(c, ru)) * strength;
        q = longint'(a*a) + longint'(b*b) + longint'(K_UNIT) * K_UNIT;
        len = int_sqrt(q << 16);
        n.nx = to_byte(a, len);
        n.ny = to_byte(b, len);
        n.nz = to_byte(K_UNIT, len);
        return 1'b1;
    endfunction

    // Neighbours of (c,r) all written, so a query stays inside the contract
    function automatic bit neighbours_known(int unsigned c, int unsigned r);
        if (c >= act_w || r >= act_h) return 1'b1;
        return written[r*MAXW + (c == 0 ? act_w - 1 : c - 1)]
            && written[r*MAXW + (c + 1 == act_w ? 0 : c + 1)]
            && written[(r == 0 ? act_h - 1 : r - 1)*MAXW + c]
            && written[(r + 1 == act_h ? 0 : r + 1)*MAXW + c];
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        case (idx)
            hnm_pkg::REG_IMAGE_WIDTH:   act_w = val[8:0] > MAXW ? MAXW : val[8:0];
            hnm_pkg::REG_IMAGE_HEIGHT:  act_h = val[8:0] > MAXH ? MAXH : val[8:0];
            hnm_pkg::REG_BUMP_STRENGTH: strength = $signed(val);
            default: ;
        endcase
    endtask

    // Offer one transaction, holding tvalid until accepted; bursts keep tvalid up
    task automatic send_item(logic op, logic [7:0] c, logic [7:0] r, logic [7:0] hv,
                             bit known, normal_t res);
        normal_t n;
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hv, r, c};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (predict_normal(op, c, r, hv, n)) begin
            if (known && n != res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row expectation disagrees with predictor");
            end
            pending_normals.push_back(known ? res : n);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Result checking against the oldest expectation
    always @(posedge aclk) begin
        normal_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser[0]};
            queries_seen++;
            if (got.bad) bad_seen++;
            if (pending_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_normals.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d bad=%0d ",
                                  "got x=%0d y=%0d z=%0d bad=%0d"},
                                 want.nx, want.ny, want.nz, want.bad,
                                 got.nx, got.ny, got.nz, got.bad);
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 7) < 5) || (($urandom & 32'h3f) == 0);
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off || !aresetn)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("height_to_normal_map_top_tb: FAIL");
            $finish;
        end
    end

    // Set the size and strength, then run random writes and queries on the image
    task automatic random_phase(int unsigned w, int unsigned h, logic [15:0] s, int items);
        normal_t none;
        int unsigned c, r;
        logic op;
        none = '0;
        write_reg(hnm_pkg::REG_IMAGE_WIDTH, 16'(w));
        write_reg(hnm_pkg::REG_IMAGE_HEIGHT, 16'(h));
        write_reg(hnm_pkg::REG_BUMP_STRENGTH, s);
        for (int i = 0; i < items; i++) begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
            end else begin
                c = $urandom_range(0, (w > MAXW ? MAXW : w) - 1);
                r = $urandom_range(0, (h > MAXH ? MAXH : h) - 1);
            end
            if (op == hnm_pkg::OP_QUERY && !neighbours_known(c, r)) op = hnm_pkg::OP_WRITE;
            send_item(op, 8'(c), 8'(r), 8'($urandom), 1'b0, none);
        end
        drain();
    endtask

    stim_row_t directed[$];
    normal_t   flat, outside, zero_n;

    initial begin
        act_w = 256; act_h = 256; strength = 256;
        flat = '{nx: 8'd128, ny: 8'd128, nz: 8'd255, bad: 1'b0};
        outside = '{nx: 8'd0, ny: 8'd0, nz: 8'd0, bad: 1'b1};
        zero_n = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: corners of a 2x2 image, wrap-around, extremes, out-of-range
        write_reg(hnm_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(hnm_pkg::REG_IMAGE_HEIGHT, 16'd2);
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd1, 8'd0, 8'd0, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd0, 8'd1, 8'd0, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd1, 8'd1, 8'd0, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 1'b1, flat});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd1, 8'd1, 8'd0, 1'b1, flat});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd2, 8'd0, 8'd0, 1'b1, outside});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd255, 8'd255, 8'd0, 1'b1, outside});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd255, 8'd255, 8'd255, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd1, 8'd0, 8'd255, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_WRITE, 8'd0, 8'd1, 8'd255, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd0, 8'd0, 8'd170, 1'b0, zero_n});
        directed.push_back('{hnm_pkg::OP_QUERY, 8'd1, 8'd1, 8'd85, 1'b0, zero_n});
        foreach (directed[i])
            send_item(directed[i].op, directed[i].col, directed[i].row,
                      directed[i].hv, directed[i].known, directed[i].res);
        drain();
        // Zero size flags everything; an unused index is ignored
        write_reg(hnm_pkg::REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_NONE, 16'hffff);
        send_item(hnm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd9, 1'b0, zero_n);
        send_item(hnm_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 1'b1, outside);
        drain();

        random_phase(3, 4, 16'h8000, 120);
        random_phase(5, 3, 16'h7fff, 120);
        random_phase(1, 1, 16'h0000, 40);
        random_phase(8, 8, 16'h0100, 150);

        // Long hold-off on the result side while the sender keeps offering queries
        fork
            random_phase(2, 2, 16'hff00, 60);
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        random_phase(511, 300, 16'hff00, 40);
        random_phase(4, 6, 16'h0480, 200);

        $display("covered: writes, queries, wraps, outside flags, sizes 0..511, strength extremes");
        $display("%0d results checked, %0d flagged outside", queries_seen, bad_seen);
        if (mismatches == 0 && pending_normals.size() == 0) begin
            $display("height_to_normal_map_top_tb: PASS");
        end else begin
            $display("height_to_normal_map_top_tb: FAIL");
        end
        $finish;
    end
endmodule

@@ height_to_normal_map_top.f @@
hdl/hnm_pkg.sv
hdl/hnm_ctrl.sv
hdl/hnm_datapath.sv
hdl/height_to_normal_map_top.sv
tb/height_to_normal_map_top_tb.sv
